FILE: design/ptc_pkg.sv
// Package for the pressure and temperature compensation pipeline.
// Holds the shift constants, the datapath widths and the register map.
// No dependencies.
`timescale 1ns / 1ps

package ptc_pkg;

  // Calibration shifts.
  localparam int SENS_SHIFT     = 15;
  localparam int OFF_SHIFT      = 17;
  localparam int TCS_SHIFT      = 7;
  localparam int TCO_SHIFT      = 5;
  localparam int TREF_SHIFT     = 7;
  localparam int TEMPSENS_SHIFT = 21;

  // Fixed scaling of the pressure equation.
  localparam int TEMP_BASE   = 2000;
  localparam int PROD_SHIFT  = 21;
  localparam int FINAL_SHIFT = 15;

  // Field widths.
  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int PRESS_W = 25;
  localparam int TEMP_W  = 21;

  // Output limits.
  localparam int P_MIN = -16777216;
  localparam int P_MAX = 16777215;
  localparam int T_MIN = -270000;
  localparam int T_MAX = 530000;

  // Internal widths, sized for the ranges of the raw fields and coefficients.
  localparam int DT_W    = RAW_W + 1;                       // signed difference
  localparam int CP_W    = DT_W + COEF_W + 1;               // dT times coefficient
  localparam int TQ_W    = CP_W - TEMPSENS_SHIFT;
  localparam int TS_W    = TQ_W + 1;                        // temperature before clamp
  localparam int OQ_W    = CP_W - TCO_SHIFT;
  localparam int OFF_W   = OQ_W + 1;
  localparam int SQ_W    = CP_W - TCS_SHIFT;
  localparam int SENS_W  = SQ_W + 1;
  localparam int SLO_W   = 18;                              // low part, unsigned
  localparam int SHI_W   = SENS_W - SLO_W;                  // high part, signed
  localparam int PLO_W   = RAW_W + SLO_W;
  localparam int PHI_W   = RAW_W + 1 + SHI_W;
  localparam int PROD_W  = PHI_W + SLO_W;
  localparam int PQ_W    = PROD_W - PROD_SHIFT;
  localparam int DIFF_W  = PQ_W + 1;
  localparam int FQ_W    = DIFF_W - FINAL_SHIFT;

  // APB register map.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_SENS     = 3'd0,
    REG_OFFSET   = 3'd1,
    REG_TCS      = 3'd2,
    REG_TCO      = 3'd3,
    REG_TREF     = 3'd4,
    REG_TEMPSENS = 3'd5
  } reg_index_t;

endpackage

FILE: design/pressure_temperature_compensation_top.sv
// Top level of the pressure and temperature compensation pipeline.
// Holds the APB calibration registers and the six-stage datapath; uses ptc_pkg.
`timescale 1ns / 1ps

// Channel      Ports                                         Transaction
// ----------   -------------------------------------------   ------------------------------
// input        start, busy, raw_pressure, raw_temperature    start high and busy low at edge
// result       done, pressure, temperature                   done high, one cycle, no stall
// config       psel, penable, pwrite, paddr, pwdata, prdata  APB write in access phase
//
// Each reading pair passes through every stage register from the accepting edge to
// the result strobe, and a new pair may be accepted in every cycle: busy is always low.
// The pipeline depth is set by the two multiplier ranks (dT times three coefficients,
// then the raw pressure times the sensitivity in two partial products) and the
// adds around them. The synchronous reset clears the valid bits and sets all
// calibration registers to zero. The receiver cannot stall, so results never wait.

module pressure_temperature_compensation_top (
  input  logic                                clk,
  input  logic                                rst,
  // Reading pair
  input  logic                                start,
  output logic                                busy,
  input  logic [ptc_pkg::RAW_W-1:0]           raw_pressure,
  input  logic [ptc_pkg::RAW_W-1:0]           raw_temperature,
  // Compensated result
  output logic                                done,
  output logic signed [ptc_pkg::PRESS_W-1:0]  pressure,
  output logic signed [ptc_pkg::TEMP_W-1:0]   temperature,
  // APB calibration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ptc_pkg::ADDR_W-1:0]          paddr,
  input  logic [ptc_pkg::DATA_W-1:0]          pwdata,
  output logic [ptc_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  import ptc_pkg::*;

  // Clamp limits at the widths of the values they are compared with.
  localparam logic signed [TS_W-1:0] T_LO = TS_W'(T_MIN);
  localparam logic signed [TS_W-1:0] T_HI = TS_W'(T_MAX);
  localparam logic signed [FQ_W-1:0] P_LO = FQ_W'(P_MIN);
  localparam logic signed [FQ_W-1:0] P_HI = FQ_W'(P_MAX);
  localparam logic signed [TS_W-1:0] T_BASE = TS_W'(TEMP_BASE);

  // ---------------------------------------------------------------------------
  // Calibration registers. Writes land in the access phase; reads are a plain
  // mux on the word index, with unused indexes reading as zero.
  // ---------------------------------------------------------------------------
  logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6;
  logic              wr_en;
  reg_index_t        wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = reg_index_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_SENS:     c1 <= pwdata[COEF_W-1:0];
        REG_OFFSET:   c2 <= pwdata[COEF_W-1:0];
        REG_TCS:      c3 <= pwdata[COEF_W-1:0];
        REG_TCO:      c4 <= pwdata[COEF_W-1:0];
        REG_TREF:     c5 <= pwdata[COEF_W-1:0];
        REG_TEMPSENS: c6 <= pwdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (wr_idx)
      REG_SENS:     prdata = {{(DATA_W-COEF_W){1'b0}}, c1};
      REG_OFFSET:   prdata = {{(DATA_W-COEF_W){1'b0}}, c2};
      REG_TCS:      prdata = {{(DATA_W-COEF_W){1'b0}}, c3};
      REG_TCO:      prdata = {{(DATA_W-COEF_W){1'b0}}, c4};
      REG_TREF:     prdata = {{(DATA_W-COEF_W){1'b0}}, c5};
      REG_TEMPSENS: prdata = {{(DATA_W-COEF_W){1'b0}}, c6};
      default:      prdata = '0;
    endcase
  end

  // The pipeline never holds off a transaction.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Pipeline registers. Only the valid bits are reset.
  // ---------------------------------------------------------------------------
  logic                     v1, v2, v3, v4, v5;
  logic [RAW_W-1:0]         d1_s1, d1_s2, d1_s3;
  logic signed [DT_W-1:0]   dt_s1;
  logic signed [CP_W-1:0]   pt_s2, po_s2, ps_s2;
  logic signed [TEMP_W-1:0] temp_s3, temp_s4, temp_s5;
  logic signed [OFF_W-1:0]  off_s3, off_s4;
  logic signed [SENS_W-1:0] sens_s3;
  logic [PLO_W-1:0]         plo_s4;
  logic signed [PHI_W-1:0]  phi_s4;
  logic signed [DIFF_W-1:0] diff_s5;

  // Stage 1: temperature difference against the shifted reference.
  logic signed [DT_W-1:0] dt_next;

  always_comb begin
    dt_next = $signed({1'b0, raw_temperature})
            - $signed({{(DT_W-COEF_W-TREF_SHIFT){1'b0}}, c5, {TREF_SHIFT{1'b0}}});
  end

  // Stage 3: the truncating divisions add 2^s-1 to negative values before the
  // arithmetic shift, so that they round toward zero.
  logic [CP_W-1:0]          pt_bias, po_bias, ps_bias;
  logic signed [TQ_W-1:0]   tq;
  logic signed [OQ_W-1:0]   oq;
  logic signed [SQ_W-1:0]   sq;
  logic signed [TS_W-1:0]   temp_sum;
  logic signed [TEMP_W-1:0] temp_next;
  logic signed [OFF_W-1:0]  off_next;
  logic signed [SENS_W-1:0] sens_next;

  always_comb begin
    pt_bias  = pt_s2 + {{(CP_W-TEMPSENS_SHIFT){1'b0}}, {TEMPSENS_SHIFT{pt_s2[CP_W-1]}}};
    po_bias  = po_s2 + {{(CP_W-TCO_SHIFT){1'b0}}, {TCO_SHIFT{po_s2[CP_W-1]}}};
    ps_bias  = ps_s2 + {{(CP_W-TCS_SHIFT){1'b0}}, {TCS_SHIFT{ps_s2[CP_W-1]}}};
    tq       = $signed(pt_bias[CP_W-1:TEMPSENS_SHIFT]);
    oq       = $signed(po_bias[CP_W-1:TCO_SHIFT]);
    sq       = $signed(ps_bias[CP_W-1:TCS_SHIFT]);
    temp_sum = $signed({tq[TQ_W-1], tq}) + T_BASE;
    if (temp_sum < T_LO) begin
      temp_next = TEMP_W'(T_LO);
    end else if (temp_sum > T_HI) begin
      temp_next = TEMP_W'(T_HI);
    end else begin
      temp_next = temp_sum[TEMP_W-1:0];
    end
    off_next  = $signed({{(OFF_W-COEF_W-OFF_SHIFT){1'b0}}, c2, {OFF_SHIFT{1'b0}}})
              + $signed({oq[OQ_W-1], oq});
    sens_next = $signed({{(SENS_W-COEF_W-SENS_SHIFT){1'b0}}, c1, {SENS_SHIFT{1'b0}}})
              + $signed({sq[SQ_W-1], sq});
  end

  // Stage 5: recombine the partial products, divide, subtract the offset.
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_bias;
  logic signed [PQ_W-1:0]   pq;
  logic signed [DIFF_W-1:0] diff_next;

  always_comb begin
    prod      = $signed({phi_s4, {SLO_W{1'b0}}})
              + $signed({{(PROD_W-PLO_W){1'b0}}, plo_s4});
    prod_bias = prod + {{(PROD_W-PROD_SHIFT){1'b0}}, {PROD_SHIFT{prod[PROD_W-1]}}};
    pq        = $signed(prod_bias[PROD_W-1:PROD_SHIFT]);
    diff_next = $signed({pq[PQ_W-1], pq})
              - $signed({{(DIFF_W-OFF_W){off_s4[OFF_W-1]}}, off_s4});
  end

  // Stage 6: final division and clamp into the pressure field.
  logic [DIFF_W-1:0]         diff_bias;
  logic signed [FQ_W-1:0]    fq;
  logic signed [PRESS_W-1:0] press_next;

  always_comb begin
    diff_bias = diff_s5
              + {{(DIFF_W-FINAL_SHIFT){1'b0}}, {FINAL_SHIFT{diff_s5[DIFF_W-1]}}};
    fq        = $signed(diff_bias[DIFF_W-1:FINAL_SHIFT]);
    if (fq < P_LO) begin
      press_next = PRESS_W'(P_LO);
    end else if (fq > P_HI) begin
      press_next = PRESS_W'(P_HI);
    end else begin
      press_next = fq[PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end

    // Stage 1
    d1_s1 <= raw_pressure;
    dt_s1 <= dt_next;
    // Stage 2: dT times the three temperature coefficients.
    d1_s2 <= d1_s1;
    pt_s2 <= dt_s1 * $signed({1'b0, c6});
    po_s2 <= dt_s1 * $signed({1'b0, c4});
    ps_s2 <= dt_s1 * $signed({1'b0, c3});
    // Stage 3
    d1_s3   <= d1_s2;
    temp_s3 <= temp_next;
    off_s3  <= off_next;
    sens_s3 <= sens_next;
    // Stage 4: raw pressure times sensitivity, split into two partial products.
    temp_s4 <= temp_s3;
    off_s4  <= off_s3;
    plo_s4  <= d1_s3 * sens_s3[SLO_W-1:0];
    phi_s4  <= $signed({1'b0, d1_s3}) * $signed(sens_s3[SENS_W-1:SLO_W]);
    // Stage 5
    temp_s5 <= temp_s4;
    diff_s5 <= diff_next;
    // Stage 6
    pressure    <= press_next;
    temperature <= temp_s5;
  end

`ifndef SYNTHESIS
  // A result strobe always traces back to a start at the accepting edge.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 6))
    else $error("result strobe without a matching input transaction");

  // The valid bits move one stage per cycle: v4 traces back through v3 and v2.
  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    v4 |-> $past(v3) && $past(v2, 2))
    else $error("pipeline valid bits out of step");

  // A delivered temperature stays inside its clamp limits.
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (temperature >= TEMP_W'(T_MIN)) && (temperature <= TEMP_W'(T_MAX)))
    else $error("temperature outside its limits");

  // A write to the temperature coefficient lands in the register.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (wr_idx == REG_TEMPSENS)) |=> (c6 == $past(pwdata[COEF_W-1:0])))
    else $error("calibration write lost");
`endif

endmodule

FILE: tb/compensation_checker.sv
// Scoreboard for the pressure and temperature compensation pipeline.
// Tracks the calibration writes, predicts each reading pair, and checks results and reads.
// Depends on ptc_pkg for widths, shifts, limits and the register map.
`timescale 1ns / 1ps

module compensation_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [ptc_pkg::RAW_W-1:0]          raw_pressure,
  input  logic [ptc_pkg::RAW_W-1:0]          raw_temperature,
  input  logic                               done,
  input  logic signed [ptc_pkg::PRESS_W-1:0] pressure,
  input  logic signed [ptc_pkg::TEMP_W-1:0]  temperature,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ptc_pkg::ADDR_W-1:0]         paddr,
  input  logic [ptc_pkg::DATA_W-1:0]         pwdata,
  input  logic [ptc_pkg::DATA_W-1:0]         prdata,
  input  logic                               pready,
  output int                                 fail_count,
  output int                                 outstanding
);

  import ptc_pkg::*;

  typedef struct packed {
    logic [PRESS_W-1:0] pressure;
    logic [TEMP_W-1:0]  temperature;
  } reading_result_t;

  logic [COEF_W-1:0] c_sens, c_off, c_tcs, c_tco, c_tref, c_tempsens;
  reading_result_t   expected_readings [$];

  // Power-of-two division that truncates toward zero, as the datapath does.
  function automatic longint trunc_shift(longint v, int s);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = mag >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic reading_result_t compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
    longint raw_p, raw_t, k1, k2, k3, k4, k5, k6;
    longint dt, temp, off, sens, p;
    reading_result_t r;
    raw_p = d1;
    raw_t = d2;
    k1 = c_sens;
    k2 = c_off;
    k3 = c_tcs;
    k4 = c_tco;
    k5 = c_tref;
    k6 = c_tempsens;
    dt   = raw_t - (k5 <<< TREF_SHIFT);
    temp = TEMP_BASE + trunc_shift(dt * k6, TEMPSENS_SHIFT);
    off  = (k2 <<< OFF_SHIFT) + trunc_shift(k4 * dt, TCO_SHIFT);
    sens = (k1 <<< SENS_SHIFT) + trunc_shift(k3 * dt, TCS_SHIFT);
    p    = trunc_shift(trunc_shift(raw_p * sens, PROD_SHIFT) - off, FINAL_SHIFT);
    p    = clamp(p, P_MIN, P_MAX);
    temp = clamp(temp, T_MIN, T_MAX);
    r.pressure    = p[PRESS_W-1:0];
    r.temperature = temp[TEMP_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reading_result_t  want;
    logic [COEF_W-1:0] reg_value;
    logic              reg_mapped;
    if (rst) begin
      c_sens     = '0;
      c_off      = '0;
      c_tcs      = '0;
      c_tco      = '0;
      c_tref     = '0;
      c_tempsens = '0;
      expected_readings.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: result with no reading pending, pressure %0d temperature %0d",
                   $time, pressure, temperature);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          if (pressure !== want.pressure) begin
            $display("%0t: pressure mismatch, expected %0d, actual %0d",
                     $time, $signed(want.pressure), pressure);
            fail_count++;
          end
          if (temperature !== want.temperature) begin
            $display("%0t: temperature mismatch, expected %0d, actual %0d",
                     $time, $signed(want.temperature), temperature);
            fail_count++;
          end
        end
      end

      if (start && !busy)
        expected_readings.push_back(compensate(raw_pressure, raw_temperature));

      reg_mapped = 1'b1;
      case (paddr[4:2])
        REG_SENS:     reg_value = c_sens;
        REG_OFFSET:   reg_value = c_off;
        REG_TCS:      reg_value = c_tcs;
        REG_TCO:      reg_value = c_tco;
        REG_TREF:     reg_value = c_tref;
        REG_TEMPSENS: reg_value = c_tempsens;
        default: begin
          reg_value  = '0;
          reg_mapped = 1'b0;
        end
      endcase

      if (psel && penable && pready && !pwrite && reg_mapped) begin
        if (prdata !== {{(DATA_W-COEF_W){1'b0}}, reg_value}) begin
          $display("%0t: register %0d read mismatch, expected %0d, actual %0d",
                   $time, paddr[4:2], reg_value, prdata);
          fail_count++;
        end
      end

      if (psel && penable && pready && pwrite) begin
        case (paddr[4:2])
          REG_SENS:     c_sens     = pwdata[COEF_W-1:0];
          REG_OFFSET:   c_off      = pwdata[COEF_W-1:0];
          REG_TCS:      c_tcs      = pwdata[COEF_W-1:0];
          REG_TCO:      c_tco      = pwdata[COEF_W-1:0];
          REG_TREF:     c_tref     = pwdata[COEF_W-1:0];
          REG_TEMPSENS: c_tempsens = pwdata[COEF_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = expected_readings.size();
  end

endmodule

FILE: tb/tb_top.sv
// Top of the testbench for the pressure and temperature compensation pipeline.
// Drives reading pairs and calibration writes; uses ptc_pkg and compensation_checker.
`timescale 1ns / 1ps

module tb_top;

  import ptc_pkg::*;

  // The two addresses past the last calibration word must not disturb anything.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam int NUM_PHASES       = 10;
  localparam int RANDOM_PER_PHASE = 200;
  // The pipeline is six stages deep; the settle wait covers it with slack to spare.
  localparam int SETTLE_CYCLES    = 10;
  // The limit leaves wide margin for a correct run even with the longest gaps everywhere.
  localparam int CYCLE_LIMIT      = 200000;

  localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [RAW_W-1:0]            raw_pressure;
  logic [RAW_W-1:0]            raw_temperature;
  logic                        done;
  logic signed [PRESS_W-1:0]   pressure;
  logic signed [TEMP_W-1:0]    temperature;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ADDR_W-1:0]           paddr;
  logic [DATA_W-1:0]           pwdata;
  logic [DATA_W-1:0]           prdata;
  logic                        pready;

  int fail_count;
  int outstanding;
  int cycles;

  // When set, the sender inserts random gaps between reading pairs.
  logic idling;

  // Local copy of the calibration, used only to aim the stimulus at the
  // reference temperature; prediction lives in the checker.
  logic [COEF_W-1:0] cal [6];

  pressure_temperature_compensation_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .done            (done),
    .pressure        (pressure),
    .temperature     (temperature),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  compensation_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .done            (done),
    .pressure        (pressure),
    .temperature     (temperature),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: a hung pipeline or handshake ends the run as a failure.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // All driving tasks start and end just after a falling edge, so the block
  // always samples settled inputs on the rising edge.

  // An APB write: setup cycle, then access cycle held until pready.
  // The upper data bits are random; the register keeps only its low 16 bits.
  task automatic apb_write(input logic [2:0] idx, input logic [COEF_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'($urandom_range(0, 65535)), value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // An APB read; the checker compares prdata in the access cycle.
  task automatic apb_read(input logic [2:0] idx);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Loads all six calibration words, pokes the two unmapped addresses, and
  // reads the whole map back to show the pokes were ignored.
  task automatic load_calibration(input logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6);
    cal[0] = c1;
    cal[1] = c2;
    cal[2] = c3;
    cal[3] = c4;
    cal[4] = c5;
    cal[5] = c6;
    apb_write(REG_SENS, c1);
    apb_write(REG_OFFSET, c2);
    apb_write(REG_TCS, c3);
    apb_write(REG_TCO, c4);
    apb_write(REG_TREF, c5);
    apb_write(REG_TEMPSENS, c6);
    apb_write(REG_SPARE_A, COEF_W'($urandom_range(0, 65535)));
    apb_write(REG_SPARE_B, COEF_W'($urandom_range(0, 65535)));
    read_back_calibration();
  endtask

  task automatic read_back_calibration();
    apb_read(REG_SENS);
    apb_read(REG_OFFSET);
    apb_read(REG_TCS);
    apb_read(REG_TCO);
    apb_read(REG_TREF);
    apb_read(REG_TEMPSENS);
  endtask

  // Presents one reading pair and holds it until the accepting edge. start
  // stays high into the next pair unless a gap is drawn.
  task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    start           = 1'b1;
    raw_pressure    = d1;
    raw_temperature = d2;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (idling && $urandom_range(0, 4) == 0) begin
      start = 1'b0;
      raw_pressure    = RAW_W'($urandom);
      raw_temperature = RAW_W'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Stops the sender and lets the pipeline empty completely. Calibration is
  // changed only after this, since the block reads it in stages 1 to 3.
  task automatic wait_for_results();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Directed pairs: the corners of both raw fields, plus readings just
  // below, at and just above the reference temperature so that dT is
  // negative, zero and positive, and one pair at mid-scale.
  task automatic run_directed();
    logic [RAW_W-1:0] ref_t;
    ref_t = {1'b0, cal[4], 7'd0};
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading('0, RAW_MAX);
    send_reading(RAW_MAX, '0);
    send_reading(RAW_MAX, ref_t);
    send_reading(RAW_MAX, ref_t - RAW_W'(1));
    send_reading(RAW_MAX, ref_t + RAW_W'(1));
    send_reading(24'h800000, 24'h7FFFFF);
  endtask

  // Random pairs. Most temperature readings sit in a window of random
  // width around the reference, which is where real sensors operate and
  // where the signed dT paths switch; the rest are uniform or corners.
  task automatic send_random_reading();
    logic [RAW_W-1:0] d1, d2, center, spread;
    int kind;
    kind   = $urandom_range(0, 9);
    d1     = RAW_W'($urandom);
    center = {1'b0, cal[4], 7'd0};
    if (kind < 6) begin
      spread = RAW_W'($urandom & ((24'd1 << $urandom_range(0, 23)) - 1));
      d2 = ($urandom_range(0, 1) == 1) ? center + spread : center - spread;
    end else if (kind < 8) begin
      d2 = RAW_W'($urandom);
    end else begin
      d1 = ($urandom_range(0, 1) == 1) ? RAW_MAX : '0;
      d2 = ($urandom_range(0, 1) == 1) ? RAW_MAX : '0;
    end
    send_reading(d1, d2);
  endtask

  // Random calibration word, pulled to an extreme now and then.
  function automatic logic [COEF_W-1:0] random_coef();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return {COEF_W{1'b1}};
    return COEF_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    raw_pressure    = '0;
    raw_temperature = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    idling          = 1'b1;
    for (int i = 0; i < 6; i++) cal[i] = '0;

    repeat (6) @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // The final phase runs back to back to show full throughput.
      idling = (phase != NUM_PHASES - 1);
      case (phase)
        // Phase zero uses the reset calibration and first confirms it reads as zero.
        0: read_back_calibration();
        1: load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_calibration(16'd36402, 16'd39473, 16'd23504, 16'd23092, 16'd33176,
                            16'd28125);
        3: load_calibration(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        4: load_calibration(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        default: load_calibration(random_coef(), random_coef(), random_coef(),
                                  random_coef(), random_coef(), random_coef());
      endcase

      if (phase < 3) run_directed();

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Halfway through each phase the sender holds off until the
        // pipeline has drained, then resumes from empty.
        if (n == RANDOM_PER_PHASE / 2) wait_for_results();
        send_random_reading();
      end
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ptc_pkg.sv
design/pressure_temperature_compensation_top.sv
tb/compensation_checker.sv
tb/tb_top.sv
